>>> hdl/euler_trs_matrix_builder_defines.svh
// assertion macros for the euler trs matrix builder
// used by the top level, expects clk_i and rst_ni in scope
`ifndef EULER_TRS_MATRIX_BUILDER_DEFINES_SVH
`define EULER_TRS_MATRIX_BUILDER_DEFINES_SVH

// same-cycle implication
`define ETMB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("etmb check failed");

// next-cycle implication
`define ETMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("etmb check failed");

`endif

>>> hdl/etmb_pkg.sv
// types, constants and fixed-point helpers of the euler trs matrix builder
// no dependencies
package etmb_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int QuadBits   = ANGLE_BITS - 2;
  localparam int TrigFrac   = 30;
  localparam int PipeDepth  = 11;
  localparam int TrigDepth  = 7;

  localparam logic signed [32:0] TRIG_ONE = 33'sd1073741824;
  localparam logic signed [32:0] C1 = 33'sd1686629713;
  localparam logic signed [32:0] C3 = -33'sd693598668;
  localparam logic signed [32:0] C5 = 33'sd85569306;
  localparam logic signed [32:0] C7 = -33'sd5026995;
  localparam logic signed [32:0] C9 = 33'sd172272;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } etmb_in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m03;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m13;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] m23;
  } etmb_res_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } etmb_trig_t;

  function automatic logic signed [32:0] ext33(input logic signed [31:0] a);
    ext33 = $signed({a[31], a});
  endfunction

  // a*b / 2^30 rounded half away from zero
  function automatic logic signed [35:0] mul_rnd(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
    logic signed [65:0] p;
    logic signed [65:0] r;
    p = 66'(a) * 66'(b);
    r = p + 66'sd536870912;
    if (p[65]) r = r - 66'sd1;
    r = r >>> TrigFrac;
    mul_rnd = r[35:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -36'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

>>> hdl/euler_trs_matrix_builder.sv
// throughput: one transfer per cycle, busy stays low, no stall on either side
// depth set by the seven-stage sine/cosine polynomial and four matrix stages
// reset: async active-low rst_ni clears the valid pipeline only
// results show on res_o for one cycle with done_o, receiver cannot stall
// depends on etmb_pkg, etmb_sincos and euler_trs_matrix_builder_defines.svh
`include "euler_trs_matrix_builder_defines.svh"

module euler_trs_matrix_builder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  etmb_pkg::etmb_in_t  in_i,
  output logic                done_o,
  output etmb_pkg::etmb_res_t res_o
);

  localparam int DlyLen = etmb_pkg::PipeDepth - 1;

  logic [etmb_pkg::PipeDepth-1:0] vld_q;
  etmb_pkg::etmb_in_t  dly_q [0:DlyLen-1];
  etmb_pkg::etmb_trig_t tx, ty, tz;

  logic signed [31:0] czcy_q, czsy_q, szsy_q, szcy_q, cysx_q, cycx_q;
  logic signed [31:0] szcx_q, szsx_q, czcx_q, czsx_q, sx_q, cx_q, nsy_q;
  logic signed [32:0] t00_q, t01_q, t02_q, t10_q, t11_q, t12_q, t20_q, t21_q, t22_q;
  logic signed [35:0] u00_q, u01_q, u02_q, u10_q, u11_q, u12_q, u20_q, u21_q, u22_q;
  etmb_pkg::etmb_res_t res_q, res_d;

  assign busy = 1'b0;

  etmb_sincos u_sc_x (.clk_i(clk_i), .angle_i(in_i.angle_x), .trig_o(tx));
  etmb_sincos u_sc_y (.clk_i(clk_i), .angle_i(in_i.angle_y), .trig_o(ty));
  etmb_sincos u_sc_z (.clk_i(clk_i), .angle_i(in_i.angle_z), .trig_o(tz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[etmb_pkg::PipeDepth-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q[0] <= in_i;
    for (int k = 1; k < DlyLen; k++) dly_q[k] <= dly_q[k-1];
    // pairwise trig products
    czcy_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(tz.c), etmb_pkg::ext33(ty.c)));
    czsy_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(tz.c), etmb_pkg::ext33(ty.s)));
    szsy_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(tz.s), etmb_pkg::ext33(ty.s)));
    szcy_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(tz.s), etmb_pkg::ext33(ty.c)));
    cysx_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(ty.c), etmb_pkg::ext33(tx.s)));
    cycx_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(ty.c), etmb_pkg::ext33(tx.c)));
    szcx_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(tz.s), etmb_pkg::ext33(tx.c)));
    szsx_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(tz.s), etmb_pkg::ext33(tx.s)));
    czcx_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(tz.c), etmb_pkg::ext33(tx.c)));
    czsx_q <= 32'(etmb_pkg::mul_rnd(etmb_pkg::ext33(tz.c), etmb_pkg::ext33(tx.s)));
    sx_q   <= tx.s;
    cx_q   <= tx.c;
    nsy_q  <= -ty.s;
    // three-term entries
    t00_q <= etmb_pkg::ext33(czcy_q);
    t01_q <= 33'(etmb_pkg::mul_rnd(etmb_pkg::ext33(czsy_q), etmb_pkg::ext33(sx_q)))
             - etmb_pkg::ext33(szcx_q);
    t02_q <= 33'(etmb_pkg::mul_rnd(etmb_pkg::ext33(czsy_q), etmb_pkg::ext33(cx_q)))
             + etmb_pkg::ext33(szsx_q);
    t10_q <= etmb_pkg::ext33(szcy_q);
    t11_q <= 33'(etmb_pkg::mul_rnd(etmb_pkg::ext33(szsy_q), etmb_pkg::ext33(sx_q)))
             + etmb_pkg::ext33(czcx_q);
    t12_q <= 33'(etmb_pkg::mul_rnd(etmb_pkg::ext33(szsy_q), etmb_pkg::ext33(cx_q)))
             - etmb_pkg::ext33(czsx_q);
    t20_q <= etmb_pkg::ext33(nsy_q);
    t21_q <= etmb_pkg::ext33(cysx_q);
    t22_q <= etmb_pkg::ext33(cycx_q);
    // row scaling
    u00_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_x), t00_q);
    u01_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_x), t01_q);
    u02_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_x), t02_q);
    u10_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_y), t10_q);
    u11_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_y), t11_q);
    u12_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_y), t12_q);
    u20_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_z), t20_q);
    u21_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_z), t21_q);
    u22_q <= etmb_pkg::mul_rnd(etmb_pkg::ext33(dly_q[DlyLen-2].scale_z), t22_q);
    res_q <= res_d;
  end

  always_comb begin
    res_d.m00 = etmb_pkg::sat32(u00_q);
    res_d.m01 = etmb_pkg::sat32(u01_q);
    res_d.m02 = etmb_pkg::sat32(u02_q);
    res_d.m03 = dly_q[DlyLen-1].pos_x;
    res_d.m10 = etmb_pkg::sat32(u10_q);
    res_d.m11 = etmb_pkg::sat32(u11_q);
    res_d.m12 = etmb_pkg::sat32(u12_q);
    res_d.m13 = dly_q[DlyLen-1].pos_y;
    res_d.m20 = etmb_pkg::sat32(u20_q);
    res_d.m21 = etmb_pkg::sat32(u21_q);
    res_d.m22 = etmb_pkg::sat32(u22_q);
    res_d.m23 = dly_q[DlyLen-1].pos_z;
  end

  assign done_o = vld_q[etmb_pkg::PipeDepth-1];
  assign res_o  = res_q;

  `ETMB_ASSERT_IMPL(a_done_follows, start, ##11 done_o)
  `ETMB_ASSERT_IMPL(a_done_source, done_o, $past(start, 11))
  `ETMB_ASSERT_IMPL(a_pos_align, done_o, res_o.m03 == $past(in_i.pos_x, 11))
  `ETMB_ASSERT_NEXT(a_zero_scale, start && (in_i.scale_z == 32'sd0), ##10 (res_o.m20 == 32'sd0))

endmodule

>>> hdl/etmb_sincos.sv
// seven-stage sine and cosine of a binary angle, q2.30 results
// depends on etmb_pkg
module etmb_sincos (
  input  logic                clk_i,
  input  logic [15:0]         angle_i,
  output etmb_pkg::etmb_trig_t trig_o
);

  logic [etmb_pkg::QuadBits-1:0] rem;
  logic [1:0]                    quad;
  logic signed [32:0]            xs;
  logic signed [32:0]            xc;

  logic signed [32:0] xs_q [0:4];
  logic signed [32:0] xc_q [0:4];
  logic signed [32:0] x2s_q [0:3];
  logic signed [32:0] x2c_q [0:3];
  logic signed [32:0] ps_q [0:3];
  logic signed [32:0] pc_q [0:3];
  logic [1:0]         q_q [0:5];
  logic signed [32:0] s6_q, c6_q;
  logic signed [32:0] s6_d, c6_d;
  logic signed [35:0] s6_m, c6_m;
  etmb_pkg::etmb_trig_t trig_q, trig_d;

  localparam logic signed [32:0] Coef [0:3] = '{etmb_pkg::C7, etmb_pkg::C5,
                                                etmb_pkg::C3, etmb_pkg::C1};

  assign quad = angle_i[etmb_pkg::ANGLE_BITS-1 -: 2];
  assign rem  = angle_i[etmb_pkg::QuadBits-1:0];
  assign xs   = $signed(33'(rem) << (etmb_pkg::TrigFrac - etmb_pkg::QuadBits));
  assign xc   = etmb_pkg::TRIG_ONE - xs;

  always_comb begin
    s6_m = etmb_pkg::mul_rnd(ps_q[3], xs_q[4]);
    c6_m = etmb_pkg::mul_rnd(pc_q[3], xc_q[4]);
    if (s6_m < 36'sd0) s6_d = '0;
    else if (s6_m > 36'(etmb_pkg::TRIG_ONE)) s6_d = etmb_pkg::TRIG_ONE;
    else s6_d = s6_m[32:0];
    if (c6_m < 36'sd0) c6_d = '0;
    else if (c6_m > 36'(etmb_pkg::TRIG_ONE)) c6_d = etmb_pkg::TRIG_ONE;
    else c6_d = c6_m[32:0];
  end

  always_comb begin
    case (q_q[5])
      2'd0: begin
        trig_d.s = s6_q[31:0];
        trig_d.c = c6_q[31:0];
      end
      2'd1: begin
        trig_d.s = c6_q[31:0];
        trig_d.c = -s6_q[31:0];
      end
      2'd2: begin
        trig_d.s = -s6_q[31:0];
        trig_d.c = -c6_q[31:0];
      end
      default: begin
        trig_d.s = -c6_q[31:0];
        trig_d.c = s6_q[31:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    xs_q[0]  <= xs;
    xc_q[0]  <= xc;
    x2s_q[0] <= 33'(etmb_pkg::mul_rnd(xs, xs));
    x2c_q[0] <= 33'(etmb_pkg::mul_rnd(xc, xc));
    q_q[0]   <= quad;
    for (int k = 1; k < 5; k++) begin
      xs_q[k] <= xs_q[k-1];
      xc_q[k] <= xc_q[k-1];
    end
    for (int k = 1; k < 4; k++) begin
      x2s_q[k] <= x2s_q[k-1];
      x2c_q[k] <= x2c_q[k-1];
    end
    for (int k = 1; k < 6; k++) q_q[k] <= q_q[k-1];
    ps_q[0] <= Coef[0] + 33'(etmb_pkg::mul_rnd(etmb_pkg::C9, x2s_q[0]));
    pc_q[0] <= Coef[0] + 33'(etmb_pkg::mul_rnd(etmb_pkg::C9, x2c_q[0]));
    for (int k = 1; k < 4; k++) begin
      ps_q[k] <= Coef[k] + 33'(etmb_pkg::mul_rnd(ps_q[k-1], x2s_q[k]));
      pc_q[k] <= Coef[k] + 33'(etmb_pkg::mul_rnd(pc_q[k-1], x2c_q[k]));
    end
    s6_q   <= s6_d;
    c6_q   <= c6_d;
    trig_q <= trig_d;
  end

  assign trig_o = trig_q;

endmodule
